### rtl/kpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypad scanner with debounce and repeat.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int CodeW    = 5;
  localparam int CountW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int DivCntW  = $clog2(CountW);

  localparam logic [CodeW-1:0] NoKey = CodeW'(16);

  localparam logic [2:0]  RowsRst    = 3'd4;
  localparam logic [2:0]  ColsRst    = 3'd4;
  localparam logic [15:0] ConfirmRst = 16'd4;
  localparam logic [15:0] RepeatRst  = 16'd400;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLS    = 2'd1,
    CFG_CONFIRM = 2'd2,
    CFG_REPEAT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic scan;
    logic div_step;
    logic update;
    logic rd;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

### rtl/kpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_ctrl
// Sequencer: accepts one beat, runs the remainder steps for a tick, then the
// debounce update; issues buffer reads when the output register is free.
// ----------------------------------------------------------------------------
module kpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             action_i,
  output logic             in_ready_o,
  input  kpd_pkg::status_t status_i,
  output kpd_pkg::cmd_t    cmd_o
);

  kpd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      kpd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i) begin
            if (status_i.out_free) begin
              cmd_o.rd = 1'b1;
            end else begin
              state_d = kpd_pkg::ST_RD_WAIT;
            end
          end else begin
            cmd_o.scan = 1'b1;
            state_d    = kpd_pkg::ST_DIV;
          end
        end
      end
      kpd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = kpd_pkg::ST_UPDATE;
        end
      end
      kpd_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = kpd_pkg::ST_IDLE;
      end
      kpd_pkg::ST_RD_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.rd = 1'b1;
          state_d  = kpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/kpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_datapath
// Config registers, matrix scan, bit-serial remainder, debounce state, key
// buffer and output register.
// ----------------------------------------------------------------------------
module kpd_datapath #(
  parameter int MAX_ROWS = 4,
  parameter int MAX_COLS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic [15:0]                          pressed_matrix_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [kpd_pkg::CodeW-1:0]            key_code_o,
  input  kpd_pkg::cmd_t                        cmd_i,
  output kpd_pkg::status_t                     status_o
);

  localparam int Cells = MAX_ROWS * MAX_COLS;

  logic [2:0]  rows_q, cols_q;
  logic [15:0] confirm_q, repeat_q;

  logic [kpd_pkg::CodeW-1:0]   first_key_q, first_key_d;
  logic [kpd_pkg::CountW-1:0]  count_q, count_d;
  logic [kpd_pkg::CodeW-1:0]   buf_key_q, buf_key_d;
  logic [kpd_pkg::CodeW-1:0]   key_q;
  logic [kpd_pkg::CountW-1:0]  dividend_q;
  logic [15:0]                 rem_q, rem_d;
  logic [kpd_pkg::DivCntW-1:0] div_cnt_q;
  logic                        out_valid_q;
  logic [kpd_pkg::CodeW-1:0]   key_code_q;

  logic [Cells-1:0]          cells;
  logic [3:0]                rows_cl, cols_cl;
  logic [kpd_pkg::CodeW-1:0] scan_key;
  logic [16:0]               trial;
  logic                      out_free;

  assign cells   = Cells'(pressed_matrix_i);
  assign rows_cl = (int'(rows_q) > MAX_ROWS) ? 4'(MAX_ROWS) : {1'b0, rows_q};
  assign cols_cl = (int'(cols_q) > MAX_COLS) ? 4'(MAX_COLS) : {1'b0, cols_q};

  // first pressed key in row-major order: walk backward so the earliest wins
  always_comb begin
    scan_key = kpd_pkg::NoKey;
    for (int r = MAX_ROWS - 1; r >= 0; r--) begin
      for (int c = MAX_COLS - 1; c >= 0; c--) begin
        if (r < int'(rows_cl) && c < int'(cols_cl) && cells[r * MAX_COLS + c]) begin
          scan_key = kpd_pkg::CodeW'(c + r * int'(cols_cl));
        end
      end
    end
  end

  assign trial = {rem_q, dividend_q[kpd_pkg::CountW-1]};
  always_comb begin
    if (trial >= {1'b0, repeat_q}) begin
      rem_d = 16'(trial - {1'b0, repeat_q});
    end else begin
      rem_d = trial[15:0];
    end
  end

  always_comb begin
    first_key_d = first_key_q;
    count_d     = count_q;
    buf_key_d   = buf_key_q;
    if (cmd_i.update) begin
      if (key_q == kpd_pkg::NoKey) begin
        count_d     = '0;
        first_key_d = kpd_pkg::NoKey;
      end else if (count_q == '0) begin
        first_key_d = key_q;
        count_d     = kpd_pkg::CountW'(1);
      end else if (key_q == first_key_q) begin
        if ((repeat_q != '0 && rem_q == '0) ||
            count_q == kpd_pkg::CountW'(confirm_q)) begin
          buf_key_d = key_q;
        end
        count_d = count_q + kpd_pkg::CountW'(1);
      end else begin
        count_d     = '0;
        first_key_d = kpd_pkg::NoKey;
      end
    end else if (cmd_i.rd) begin
      buf_key_d = kpd_pkg::NoKey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= kpd_pkg::RowsRst;
      cols_q      <= kpd_pkg::ColsRst;
      confirm_q   <= kpd_pkg::ConfirmRst;
      repeat_q    <= kpd_pkg::RepeatRst;
      first_key_q <= kpd_pkg::NoKey;
      count_q     <= '0;
      buf_key_q   <= kpd_pkg::NoKey;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (kpd_pkg::cfg_idx_e'(cfg_idx_i))
          kpd_pkg::CFG_ROWS:    rows_q    <= cfg_wdata_i[2:0];
          kpd_pkg::CFG_COLS:    cols_q    <= cfg_wdata_i[2:0];
          kpd_pkg::CFG_CONFIRM: confirm_q <= cfg_wdata_i;
          kpd_pkg::CFG_REPEAT:  repeat_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      first_key_q <= first_key_d;
      count_q     <= count_d;
      buf_key_q   <= buf_key_d;
      if (cmd_i.scan) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + kpd_pkg::DivCntW'(1);
      end
      if (cmd_i.rd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      key_q      <= scan_key;
      dividend_q <= count_q;
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[kpd_pkg::CountW-2:0], 1'b0};
      rem_q      <= rem_d;
    end
    if (cmd_i.rd) begin
      key_code_q <= buf_key_q;
    end
  end

  assign out_free          = !out_valid_q || out_ready_i;
  assign status_o.out_free = out_free;
  assign status_o.div_last = (div_cnt_q == kpd_pkg::DivCntW'(kpd_pkg::CountW - 1));
  assign out_valid_o       = out_valid_q;
  assign key_code_o        = key_code_q;

endmodule

### rtl/keypad_scan_debounce_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_repeat_core
// Matrix keypad scanner with debounce, auto-repeat and a one-key buffer.
//
//   channel  signals                               direction
//   in       in_valid_i/in_ready_o, action_i,      beat in
//            pressed_matrix_i
//   out      out_valid_o/out_ready_i, key_code_o   beat out (reads only)
//   cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i      write, no wait
//
// A scan tick runs the bit-serial remainder of the 32-bit count by the repeat
// period, one count bit per step in ST_DIV, then the debounce update in
// ST_UPDATE, and returns to idle with ready high.
// A read waits only while the output register is full and out_ready_i is low.
// Reset clears the debounce state, the buffer and the output valid.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat_core #(
  parameter int MAX_ROWS = 4,
  parameter int MAX_COLS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [15:0]                  pressed_matrix_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kpd_pkg::CodeW-1:0]    key_code_o,
  input  logic                         cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  kpd_pkg::cmd_t    cmd;
  kpd_pkg::status_t status;

  kpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kpd_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pressed_matrix_i (pressed_matrix_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .key_code_o       (key_code_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i |=> !in_ready_o)
    else $error("ready during tick processing");

  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i |-> ##34 in_ready_o)
    else $error("tick did not finish in 34 cycles");

  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i && (!out_valid_o || out_ready_i)
    |=> out_valid_o && key_code_o <= kpd_pkg::NoKey)
    else $error("read did not load a valid key code");

endmodule
